@@ rtl/annexb_pkg.sv @@
package annexb_pkg;

  // look-ahead window depth and its index/count width
  localparam int LA_DEPTH = 5;
  localparam int LA_W     = $clog2(LA_DEPTH + 1);

  localparam logic [15:0] MAX_PKT_RESET = 16'd4096;

  // NAL header type field and the slice types that get a timestamp
  localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
  localparam logic [4:0] NAL_SLICE     = 5'd1;
  localparam logic [4:0] NAL_IDR       = 5'd5;

  // start code bytes and lengths
  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;
  localparam logic [2:0] SC_NONE = 3'd0;
  localparam logic [2:0] SC_LEN3 = 3'd3;
  localparam logic [2:0] SC_LEN4 = 3'd4;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_NO_START,
    ERR_END_CODE,
    ERR_ADJACENT
  } err_t;

  typedef enum logic [1:0] {
    PH_BOUNDARY,
    PH_INSIDE,
    PH_HALTED
  } phase_t;

  typedef enum logic [1:0] {
    MODE_RUN,
    MODE_FLUSH,
    MODE_FINAL
  } mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        packet_start;
    logic        packet_end;
    logic        unit_start;
    logic        unit_end;
    logic        has_timestamp;
    logic [63:0] timestamp;
    logic        stream_done;
    err_t        error_code;
  } out_word_t;

endpackage

@@ rtl/annexb_nal_splitter.sv @@
// Path: an accepted byte word passes the input register, the window, then the result
//   register; throughput one byte word per cycle in steady state while res_stall is low.
// End of stream: the word with last_byte set drains the 5-byte window one byte per
//   cycle while res_stall is low, then issues the stream_done word; input stalls meanwhile.
// Reset (rst, synchronous): empties window and result path, clears stream state,
//   max_packet_bytes returns to 4096.
module annexb_nal_splitter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  annexb_pkg::in_word_t  byte_data,
  output logic                  res_valid,
  input  logic                  res_stall,
  output annexb_pkg::out_word_t res_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_data
);

  localparam int LD = annexb_pkg::LA_DEPTH;
  localparam int LW = annexb_pkg::LA_W;

  logic [15:0]           max_packet_bytes;

  // input register
  logic                  a_valid;
  annexb_pkg::in_word_t  a_word;

  // window and stream state
  logic [7:0]            win [LD];
  logic [LW-1:0]         cnt;
  logic [LW-1:0]         fl_n;
  annexb_pkg::phase_t    phase;
  logic [15:0]           fill;
  logic [2:0]            scr;
  logic                  stamped;
  logic [63:0]           stamp;
  logic [63:0]           counter;
  annexb_pkg::err_t      err;
  annexb_pkg::mode_t     mode, mode_next;

  // hold word for flush, result register
  logic                  h_valid;
  annexb_pkg::out_word_t h_word;
  logic                  r_valid;
  annexb_pkg::out_word_t r_word;
  annexb_pkg::out_word_t f_word;

  // control
  logic                  go;
  logic                  a_take;
  logic                  do_take;

  // take datapath
  logic [7:0]            tw [LD];
  logic [LW-1:0]         tn;
  logic [2:0]            code0, code1;
  logic [4:0]            nal_type;
  logic [15:0]           limit;
  logic                  pend, ustart, uend, res_stamped;
  logic                  t_emit;
  annexb_pkg::out_word_t t_res;
  annexb_pkg::phase_t    t_phase;
  logic [15:0]           t_fill;
  logic [2:0]            t_scr;
  logic                  t_stamped;
  logic [63:0]           t_stamp;
  logic [63:0]           t_counter;
  annexb_pkg::err_t      t_err;

  // mode next state
  always_comb begin
    mode_next = mode;
    case (mode)
      annexb_pkg::MODE_RUN: begin
        if (a_take && a_word.last_byte) mode_next = annexb_pkg::MODE_FLUSH;
      end
      annexb_pkg::MODE_FLUSH: begin
        if (go && fl_n == LW'(1)) mode_next = annexb_pkg::MODE_FINAL;
      end
      annexb_pkg::MODE_FINAL: begin
        if (go) mode_next = annexb_pkg::MODE_RUN;
      end
      default: mode_next = annexb_pkg::MODE_RUN;
    endcase
  end

  // handshake and step control
  always_comb begin
    go         = !r_valid || !res_stall;
    a_take     = a_valid && go && (mode == annexb_pkg::MODE_RUN);
    byte_stall = a_valid && !a_take;
    do_take    = (a_take && !a_word.last_byte && cnt == LW'(LD - 1)) ||
                 (mode == annexb_pkg::MODE_FLUSH);
    res_valid  = r_valid;
    res_data   = r_word;
    cfg_ready  = 1'b1;
  end

  // window as seen by one take; in run mode the new byte fills the top slot
  always_comb begin
    for (int i = 0; i < LD; i++) tw[i] = win[i];
    if (mode == annexb_pkg::MODE_RUN) tw[LD-1] = a_word.data_byte;
    tn = (mode == annexb_pkg::MODE_FLUSH) ? fl_n : LW'(LD);
  end

  // start code at the oldest byte and right after it
  always_comb begin
    code0 = annexb_pkg::SC_NONE;
    if (tn >= LW'(4) && tw[0] == annexb_pkg::SC_ZERO && tw[1] == annexb_pkg::SC_ZERO &&
        tw[2] == annexb_pkg::SC_ZERO && tw[3] == annexb_pkg::SC_ONE)
      code0 = annexb_pkg::SC_LEN4;
    else if (tn >= LW'(3) && tw[0] == annexb_pkg::SC_ZERO &&
             tw[1] == annexb_pkg::SC_ZERO && tw[2] == annexb_pkg::SC_ONE)
      code0 = annexb_pkg::SC_LEN3;

    code1 = annexb_pkg::SC_NONE;
    if (tn >= LW'(5) && tw[1] == annexb_pkg::SC_ZERO && tw[2] == annexb_pkg::SC_ZERO &&
        tw[3] == annexb_pkg::SC_ZERO && tw[4] == annexb_pkg::SC_ONE)
      code1 = annexb_pkg::SC_LEN4;
    else if (tn >= LW'(4) && tw[1] == annexb_pkg::SC_ZERO &&
             tw[2] == annexb_pkg::SC_ZERO && tw[3] == annexb_pkg::SC_ONE)
      code1 = annexb_pkg::SC_LEN3;
  end

  // one take of the oldest window byte
  always_comb begin
    t_phase     = phase;
    t_fill      = fill;
    t_scr       = scr;
    t_stamped   = stamped;
    t_stamp     = stamp;
    t_counter   = counter;
    t_err       = err;
    t_emit      = 1'b0;
    ustart      = 1'b0;
    uend        = 1'b0;
    nal_type    = '0;
    res_stamped = 1'b0;
    t_res       = '0;
    limit       = (max_packet_bytes == 16'd0) ? 16'd1 : max_packet_bytes;

    // boundary: a start code must open the next unit
    if (phase == annexb_pkg::PH_BOUNDARY) begin
      if (code0 == annexb_pkg::SC_NONE) begin
        t_phase = annexb_pkg::PH_HALTED;
        if (err == annexb_pkg::ERR_NONE) t_err = annexb_pkg::ERR_NO_START;
      end else begin
        nal_type  = ((code0 == annexb_pkg::SC_LEN4) ? tw[4][4:0] : tw[3][4:0]) &
                    annexb_pkg::NAL_TYPE_MASK;
        t_stamped = (tn > LW'(code0)) &&
                    (nal_type == annexb_pkg::NAL_SLICE || nal_type == annexb_pkg::NAL_IDR);
        if (t_stamped) begin
          t_stamp   = counter;
          t_counter = counter + 64'd1;
        end
        t_scr   = code0;
        ustart  = 1'b1;
        t_phase = annexb_pkg::PH_INSIDE;
      end
    end

    // inside a unit: start code bytes, then payload up to the next code
    if (t_phase == annexb_pkg::PH_INSIDE) begin
      if (t_scr != 3'd0) begin
        if (t_scr == 3'd1 && tn <= LW'(1)) begin
          t_phase = annexb_pkg::PH_HALTED;
          if (err == annexb_pkg::ERR_NONE) t_err = annexb_pkg::ERR_END_CODE;
        end else if (t_scr == 3'd1 && code1 != annexb_pkg::SC_NONE) begin
          t_phase = annexb_pkg::PH_HALTED;
          if (err == annexb_pkg::ERR_NONE) t_err = annexb_pkg::ERR_ADJACENT;
        end else begin
          t_emit = 1'b1;
          t_scr  = t_scr - 3'd1;
        end
      end else begin
        uend   = (tn <= LW'(1)) || (code1 != annexb_pkg::SC_NONE);
        t_emit = 1'b1;
        if (uend) t_phase = annexb_pkg::PH_BOUNDARY;
      end
    end

    // result word and packet bookkeeping
    pend = uend || ({1'b0, fill} + 17'd1 >= {1'b0, limit});
    if (t_emit) begin
      res_stamped         = t_stamped;
      t_res.out_byte      = tw[0];
      t_res.packet_start  = (fill == 16'd0);
      t_res.packet_end    = pend;
      t_res.unit_start    = ustart;
      t_res.unit_end      = uend;
      t_res.has_timestamp = res_stamped;
      t_res.timestamp     = res_stamped ? t_stamp : 64'd0;
      t_res.stream_done   = 1'b0;
      t_res.error_code    = t_err;
      if (pend) begin
        t_fill    = 16'd0;
        t_stamped = 1'b0;
      end else begin
        t_fill = fill + 16'd1;
      end
    end
  end

  // stream_done word: the held byte word or an empty one, with the final latch
  always_comb begin
    f_word             = h_valid ? h_word : '0;
    f_word.stream_done = 1'b1;
    f_word.error_code  = err;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_bytes <= annexb_pkg::MAX_PKT_RESET;
      a_valid <= 1'b0;
      mode    <= annexb_pkg::MODE_RUN;
      cnt     <= '0;
      fl_n    <= '0;
      phase   <= annexb_pkg::PH_BOUNDARY;
      fill    <= '0;
      scr     <= '0;
      stamped <= 1'b0;
      counter <= '0;
      err     <= annexb_pkg::ERR_NONE;
      h_valid <= 1'b0;
      r_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) max_packet_bytes <= cfg_data;

      if (byte_valid && !byte_stall) a_valid <= 1'b1;
      else if (a_take) a_valid <= 1'b0;

      mode <= mode_next;

      if (go) begin
        case (mode)
          annexb_pkg::MODE_RUN: begin
            r_valid <= do_take && t_emit;
            if (a_take && a_word.last_byte) fl_n <= cnt + LW'(1);
            else if (a_take && cnt != LW'(LD - 1)) cnt <= cnt + LW'(1);
          end
          annexb_pkg::MODE_FLUSH: begin
            r_valid <= t_emit && h_valid;
            fl_n    <= fl_n - LW'(1);
            if (t_emit) h_valid <= 1'b1;
          end
          annexb_pkg::MODE_FINAL: begin
            r_valid <= 1'b1;
            h_valid <= 1'b0;
            cnt     <= '0;
          end
          default: r_valid <= 1'b0;
        endcase

        // stream state: commit a take, or start anew after stream_done
        if (mode == annexb_pkg::MODE_FINAL) begin
          phase   <= annexb_pkg::PH_BOUNDARY;
          fill    <= '0;
          scr     <= '0;
          stamped <= 1'b0;
          counter <= '0;
          err     <= annexb_pkg::ERR_NONE;
        end else if (do_take) begin
          phase   <= t_phase;
          fill    <= t_fill;
          scr     <= t_scr;
          stamped <= t_stamped;
          counter <= t_counter;
          err     <= t_err;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) a_word <= byte_data;

    if (go) begin
      if (do_take) stamp <= t_stamp;

      // window: shift out the oldest byte on a take, else append
      if (do_take) begin
        for (int i = 0; i < LD - 1; i++) win[i] <= tw[i+1];
        win[LD-1] <= '0;
      end else if (a_take) begin
        win[cnt[LW-1:0]] <= a_word.data_byte;
      end

      case (mode)
        annexb_pkg::MODE_RUN: begin
          r_word <= t_res;
        end
        annexb_pkg::MODE_FLUSH: begin
          r_word <= h_word;
          if (t_emit) h_word <= t_res;
        end
        annexb_pkg::MODE_FINAL: begin
          r_word <= f_word;
        end
        default: r_word <= '0;
      endcase
    end
  end

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= LW'(LD - 1))
    else $error("window count beyond depth minus one");

  a_hold_in_flush: assert property (@(posedge clk) disable iff (rst)
    h_valid |-> mode != annexb_pkg::MODE_RUN)
    else $error("hold word left over outside flush");

  a_stream_clear: assert property (@(posedge clk) disable iff (rst)
    (mode == annexb_pkg::MODE_FINAL && go) |=>
      (cnt == '0 && err == annexb_pkg::ERR_NONE && counter == '0 &&
       phase == annexb_pkg::PH_BOUNDARY))
    else $error("stream state not cleared after stream_done");

  a_unit_end_pkt: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.unit_end) |-> res_data.packet_end)
    else $error("unit end without packet end");

  a_stamp_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_data.has_timestamp) |-> res_data.timestamp == 64'd0)
    else $error("timestamp nonzero on unstamped word");

endmodule
